/* design/g2g_pkg.sv */
// Shared types, widths and constants for the go-to-goal steering controller.
// Has no dependencies. Every other design file imports it.
package g2g_pkg;

	// Field widths.
	localparam int PW = 18;                 // position and goal
	localparam int HW = 15;                 // heading
	localparam int TW = 17;                 // arrival tolerance
	localparam int GW = 12;                 // gains
	localparam int LW = 19;                 // linear speed
	localparam int RW = 20;                 // turn rate

	// Internal widths of the rotation datapath.
	localparam int GUARD = 8;               // guard bits added to the vector
	localparam int XW = 30;                 // CORDIC x and y
	localparam int ZW = 24;                 // CORDIC angle, Q20
	localparam int KW = 17;                 // reciprocal gain constant

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_ENTRIES = 24;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PW = $clog2(FIFO_DEPTH);

	localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
	localparam logic [KW-1:0] INV_GAIN_Q16 = 17'd39796;
	localparam logic [LW-1:0] LIN_MAX = 19'd524287;
	localparam logic signed [RW-1:0] TURN_MAX = 20'sd524287;
	localparam logic signed [RW-1:0] TURN_MIN = -20'sd524288;

	// Register map: index = byte address / 4.
	localparam int AW = 5;
	localparam logic [2:0] REG_GOAL_X = 3'd0;
	localparam logic [2:0] REG_GOAL_Y = 3'd1;
	localparam logic [2:0] REG_ARRIVE_TOL = 3'd2;
	localparam logic [2:0] REG_LIN_GAIN = 3'd3;
	localparam logic [2:0] REG_ANG_GAIN = 3'd4;

	localparam logic [PW-1:0] GOAL_X_RST = 18'd8192;
	localparam logic [PW-1:0] GOAL_Y_RST = 18'd8192;
	localparam logic [TW-1:0] ARRIVE_TOL_RST = 17'd41;
	localparam logic [GW-1:0] LIN_GAIN_RST = 12'd384;
	localparam logic [GW-1:0] ANG_GAIN_RST = 12'd1024;

	// One classified request waiting for the rotation pipeline.
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic signed [HW-1:0] hd;
	} item_t;

	// Settings used by the back end.
	typedef struct packed {
		logic [TW-1:0] tol;
		logic [GW-1:0] lin_gain;
		logic [GW-1:0] ang_gain;
	} back_cfg_t;

	// atan(2^-i) in Q20, rounded to nearest.
	function automatic logic signed [ZW-1:0] atan_q20(input int idx);
		logic signed [ZW-1:0] r;
		case (idx)
			0: r = 24'sd823550;
			1: r = 24'sd486170;
			2: r = 24'sd256879;
			3: r = 24'sd130396;
			4: r = 24'sd65451;
			5: r = 24'sd32757;
			6: r = 24'sd16383;
			7: r = 24'sd8192;
			8: r = 24'sd4096;
			9: r = 24'sd2048;
			10: r = 24'sd1024;
			11: r = 24'sd512;
			12: r = 24'sd256;
			13: r = 24'sd128;
			14: r = 24'sd64;
			15: r = 24'sd32;
			16: r = 24'sd16;
			17: r = 24'sd8;
			18: r = 24'sd4;
			19: r = 24'sd2;
			20: r = 24'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* design/g2g_regs.sv */
// APB-style register file holding the goal, tolerance and gains.
// Depends on g2g_pkg for widths, register indexes and reset values.
module g2g_regs
	import g2g_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AW-1:0]        paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output logic signed [PW-1:0] goal_x,
	output logic signed [PW-1:0] goal_y,
	output back_cfg_t            back_cfg
);

	logic [PW-1:0] goal_x_q;
	logic [PW-1:0] goal_y_q;
	logic [TW-1:0] tol_q;
	logic [GW-1:0] lin_gain_q;
	logic [GW-1:0] ang_gain_q;
	logic [2:0]    idx;
	logic          wr_en;

	assign idx = paddr[AW-1:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q <= GOAL_X_RST;
			goal_y_q <= GOAL_Y_RST;
			tol_q <= ARRIVE_TOL_RST;
			lin_gain_q <= LIN_GAIN_RST;
			ang_gain_q <= ANG_GAIN_RST;
		end else if (wr_en) begin
			case (idx)
				REG_GOAL_X: goal_x_q <= pwdata[PW-1:0];
				REG_GOAL_Y: goal_y_q <= pwdata[PW-1:0];
				REG_ARRIVE_TOL: tol_q <= pwdata[TW-1:0];
				REG_LIN_GAIN: lin_gain_q <= pwdata[GW-1:0];
				REG_ANG_GAIN: ang_gain_q <= pwdata[GW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GOAL_X: prdata = {{(32-PW){1'b0}}, goal_x_q};
			REG_GOAL_Y: prdata = {{(32-PW){1'b0}}, goal_y_q};
			REG_ARRIVE_TOL: prdata = {{(32-TW){1'b0}}, tol_q};
			REG_LIN_GAIN: prdata = {{(32-GW){1'b0}}, lin_gain_q};
			REG_ANG_GAIN: prdata = {{(32-GW){1'b0}}, ang_gain_q};
			default: prdata = '0;
		endcase
	end

	assign goal_x = $signed(goal_x_q);
	assign goal_y = $signed(goal_y_q);
	assign back_cfg.tol = tol_q;
	assign back_cfg.lin_gain = lin_gain_q;
	assign back_cfg.ang_gain = ang_gain_q;

endmodule

/* design/g2g_front.sv */
// Front end: accepts pose requests, forms the goal vector and folds it into
// the right half plane. Depends on g2g_pkg.
module g2g_front
	import g2g_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic signed [PW-1:0] goal_x,
	input  logic signed [PW-1:0] goal_y,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [PW-1:0] pos_x,
	input  logic signed [PW-1:0] pos_y,
	input  logic signed [HW-1:0] heading,
	input  logic                 q_full,
	output logic                 q_push,
	output item_t                q_item
);

	logic signed [PW:0]   dx;
	logic signed [PW:0]   dy;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	item_t                cls;
	item_t                item_s1;
	logic                 valid_s1;
	logic                 load;

	assign dx = {goal_x[PW-1], goal_x} - {pos_x[PW-1], pos_x};
	assign dy = {goal_y[PW-1], goal_y} - {pos_y[PW-1], pos_y};
	assign xs = {{(XW-PW-1-GUARD){dx[PW]}}, dx, {GUARD{1'b0}}};
	assign ys = {{(XW-PW-1-GUARD){dy[PW]}}, dy, {GUARD{1'b0}}};

	// Vectors in the left half plane are turned by a quarter turn first.
	always_comb begin
		cls.hd = heading;
		if (xs < 0) begin
			if (ys >= 0) begin
				cls.x = ys;
				cls.y = -xs;
				cls.z = HALF_PI_Q20;
			end else begin
				cls.x = -ys;
				cls.y = xs;
				cls.z = -HALF_PI_Q20;
			end
		end else begin
			cls.x = xs;
			cls.y = ys;
			cls.z = '0;
		end
	end

	assign in_stall = valid_s1 && q_full;
	assign load = in_valid && !in_stall;
	assign q_push = valid_s1 && !q_full;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= cls;
		end
	end

endmodule

/* design/g2g_fifo.sv */
// Short request queue between the front end and the rotation back end.
// Depends on g2g_pkg for the entry type and depth.
module g2g_fifo
	import g2g_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wr_item,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output item_t rd_item
);

	item_t              mem_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0] wr_ptr_q;
	logic [FIFO_PW-1:0] rd_ptr_q;
	logic [FIFO_PW:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full = (cnt_q == (FIFO_PW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

/* design/g2g_back.sv */
// Back end: pipelined CORDIC vectoring, distance and bearing scaling, the
// arrival test, gain products, saturation and the output register. Uses g2g_pkg.
module g2g_back
	import g2g_pkg::*;
#(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  back_cfg_t            cfg,
	input  logic                 q_empty,
	input  item_t                q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [LW-1:0]        linear_speed,
	output logic signed [RW-1:0] turn_rate,
	output logic                 arrived
);

	logic                 en;
	logic signed [XW-1:0] x_s [0:STAGES];
	logic signed [XW-1:0] y_s [0:STAGES];
	logic signed [ZW-1:0] z_s [0:STAGES];
	logic signed [HW-1:0] hd_s [0:STAGES];
	logic                 v_s [0:STAGES];

	// Whole pipeline advances together unless a finished result is held.
	assign en = !out_valid || !out_stall;
	assign q_pop = en && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= q_item.x;
			y_s[0] <= q_item.y;
			z_s[0] <= q_item.z;
			hd_s[0] <= q_item.hd;
		end
	end

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam logic signed [ZW-1:0] ANG = atan_q20(k);
		logic signed [XW-1:0] xsh;
		logic signed [XW-1:0] ysh;

		assign xsh = x_s[k] >>> k;
		assign ysh = y_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hd_s[k+1] <= hd_s[k];
				if (y_s[k] >= 0) begin
					x_s[k+1] <= x_s[k] + ysh;
					y_s[k+1] <= y_s[k] - xsh;
					z_s[k+1] <= z_s[k] + ANG;
				end else begin
					x_s[k+1] <= x_s[k] - ysh;
					y_s[k+1] <= y_s[k] + xsh;
					z_s[k+1] <= z_s[k] - ANG;
				end
			end
		end
	end

	// Stage 1: gain correction product and heading error.
	logic signed [XW+KW:0] prod;
	logic signed [ZW:0]    bsum;
	logic signed [16:0]    bear;
	logic signed [17:0]    herr;
	logic signed [XW+KW:0] prod_s1;
	logic signed [17:0]    herr_s1;
	logic                  v_s1;

	assign prod = x_s[STAGES] * $signed({1'b0, INV_GAIN_Q16});
	assign bsum = {z_s[STAGES][ZW-1], z_s[STAGES]} + (ZW+1)'(128);
	assign bear = bsum[ZW:8];
	assign herr = {bear[16], bear} - {{3{hd_s[STAGES][HW-1]}}, hd_s[STAGES]};

	// Stage 2: distance, arrival test and the two gain products.
	logic signed [XW+KW:0] dsum;
	logic signed [20:0]    distance;
	logic                  arr;
	logic [GW+19:0]        lp;
	logic signed [GW+18:0] tp;
	logic [GW+19:0]        lp_s2;
	logic signed [GW+18:0] tp_s2;
	logic                  arr_s2;
	logic                  v_s2;

	assign dsum = prod_s1 + (XW+KW+1)'(64'd8388608);
	assign distance = dsum[44:24];
	assign arr = distance <= $signed({4'b0, cfg.tol});
	assign lp = cfg.lin_gain * distance[19:0];
	assign tp = $signed({1'b0, cfg.ang_gain}) * herr_s1;

	// Output stage: rounding and saturation.
	logic [GW+20:0]        lsum;
	logic [GW+12:0]        lr;
	logic signed [GW+19:0] tsum;
	logic signed [GW+11:0] tr;
	logic [LW-1:0]         lin_sat;
	logic signed [RW-1:0]  turn_sat;

	assign lsum = {1'b0, lp_s2} + (GW+21)'(128);
	assign lr = lsum[GW+20:8];
	assign tsum = {tp_s2[GW+18], tp_s2} + (GW+20)'(128);
	assign tr = tsum[GW+19:8];

	always_comb begin
		if (lr > {{(GW+13-LW){1'b0}}, LIN_MAX}) begin
			lin_sat = LIN_MAX;
		end else begin
			lin_sat = lr[LW-1:0];
		end
		if (tr > $signed({{(GW+12-RW){TURN_MAX[RW-1]}}, TURN_MAX})) begin
			turn_sat = TURN_MAX;
		end else if (tr < $signed({{(GW+12-RW){TURN_MIN[RW-1]}}, TURN_MIN})) begin
			turn_sat = TURN_MIN;
		end else begin
			turn_sat = tr[RW-1:0];
		end
	end

	logic                 out_valid_q;
	logic [LW-1:0]        lin_q;
	logic signed [RW-1:0] turn_q;
	logic                 arr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= v_s[STAGES];
			v_s2 <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
			herr_s1 <= herr;
			lp_s2 <= lp;
			tp_s2 <= tp;
			arr_s2 <= arr;
			arr_q <= arr_s2;
			if (arr_s2) begin
				lin_q <= '0;
				turn_q <= '0;
			end else begin
				lin_q <= lin_sat;
				turn_q <= turn_sat;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign linear_speed = lin_q;
	assign turn_rate = turn_q;
	assign arrived = arr_q;

endmodule

/* design/go_to_goal_controller.sv */
// Top level of the proportional go-to-goal steering controller.
// Depends on g2g_pkg, g2g_regs, g2g_front, g2g_fifo and g2g_back.
//
// For every pose request (pos_x, pos_y, heading) the controller forms the
// vector to the programmed goal, runs it through a pipelined CORDIC in
// vectoring mode to get distance and bearing, and returns one result: when the
// distance is above arrive_tolerance, linear_speed is linear_gain times the
// distance and turn_rate is angular_gain times (bearing minus heading), both
// rounded and saturated, with the heading error not wrapped; otherwise both
// speeds are zero and arrived is set. Positions and angles are Q12 and gains
// are Q8. The block takes one request per clock cycle while in_stall is low
// and returns results in order. The front-end register that forms and folds
// the vector is loaded at the accepting edge; from there a request passes
// into the request queue, from the queue into the CORDIC input register,
// through the CORDIC iteration registers, through the stage 1 and stage 2
// registers for the gain products and into the output register. A stall on
// the output freezes the back end only; the front end keeps filling a
// four-entry queue and then stalls the input. The registers are to be
// written through the APB port only while no request is in flight; the
// block itself does not enforce this. goal_x, goal_y, arrive_tolerance,
// linear_gain and angular_gain lie at byte addresses 0, 4, 8, 12 and 16.
module go_to_goal_controller
	import g2g_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AW-1:0]        paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [PW-1:0] pos_x,
	input  logic signed [PW-1:0] pos_y,
	input  logic signed [HW-1:0] heading,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [LW-1:0]        linear_speed,
	output logic signed [RW-1:0] turn_rate,
	output logic                 arrived
);

	logic signed [PW-1:0] goal_x;
	logic signed [PW-1:0] goal_y;
	back_cfg_t            back_cfg;
	logic                 q_push;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_empty;
	item_t                q_wr_item;
	item_t                q_rd_item;

	// Configuration registers.
	g2g_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.goal_x   (goal_x),
		.goal_y   (goal_y),
		.back_cfg (back_cfg)
	);

	// The front end accepts a request and classifies its goal vector by
	// quadrant so that the CORDIC only sees vectors in the right half plane.
	g2g_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.goal_x   (goal_x),
		.goal_y   (goal_y),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.heading  (heading),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_wr_item)
	);

	// The queue lets the front end keep accepting while the back end is held.
	g2g_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (q_wr_item),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.rd_item (q_rd_item)
	);

	// The back end does the rotation, scaling, arrival test and saturation.
	g2g_back #(
		.STAGES (CORDIC_STAGES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (back_cfg),
		.q_empty      (q_empty),
		.q_item       (q_rd_item),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.linear_speed (linear_speed),
		.turn_rate    (turn_rate),
		.arrived      (arrived)
	);

endmodule
